/* design/hlc_pkg.sv */
// Shared constants, types and decode helpers for the HSV to CMY lattice interpolator.
// Used by the controller, the datapath and the top level; depends on nothing else.
package hlc_pkg;

   // Lattice geometry
   localparam int HUE_STEPS    = 48;
   localparam int SV_LEVELS    = 17;
   localparam int HUE_GRID_LOG = 5;
   localparam int SV_GRID_LOG  = 4;
   localparam int SV_GRID      = 1 << SV_GRID_LOG;
   localparam int PLANE_SIZE   = SV_LEVELS * HUE_STEPS;
   localparam int TABLE_DEPTH  = SV_LEVELS * PLANE_SIZE;

   // Field and internal widths
   localparam int HUE_W       = 11;
   localparam int SV_W        = 8;
   localparam int CHAN_W      = 8;
   localparam int ENTRY_W     = 3 * CHAN_W;
   localparam int INDEX_W     = 14;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int HSTEP_RAW_W = HUE_W + 1 - HUE_GRID_LOG;
   localparam int HSTEP_W     = $clog2(HUE_STEPS);
   localparam int LVL_W       = $clog2(SV_LEVELS);
   localparam int HUE_MAG_W   = HUE_GRID_LOG;
   localparam int SV_MAG_W    = SV_GRID_LOG;

   // Saturation / value edge rule: 256 becomes 255, whose neighbor 239 reads level 14
   localparam int SV_TOP           = SV_LEVELS - 1;
   localparam int SV_EDGE          = 255;
   localparam int SV_EDGE_NB_LEVEL = (SV_EDGE - SV_GRID) / SV_GRID;

   // Fixed point: 8 fraction bits; the top cell spans 15 instead of 16
   localparam int FRAC_W       = 8;
   localparam int DEN_EDGE     = SV_GRID - 1;
   localparam int DEN15_WHOLE  = (1 << FRAC_W) / DEN_EDGE;
   localparam int DIV15_SHIFT  = 16;
   localparam int DIV15_MUL    = ((1 << DIV15_SHIFT) + DEN_EDGE - 1) / DEN_EDGE;

   // Action codes
   localparam logic ACT_WRITE   = 1'b0;
   localparam logic ACT_CONVERT = 1'b1;

   typedef enum logic [1:0] {
      SEL_NEAR,
      SEL_HUE,
      SEL_SAT,
      SEL_VAL
   } lattice_sel_type;

   typedef struct packed {
      logic [LVL_W-1:0]    lvl0;
      logic [LVL_W-1:0]    lvl_nb;
      logic [SV_MAG_W-1:0] mag;
      logic                den15;
   } sv_axis_type;

   typedef struct packed {
      logic            load;
      logic            mem_we;
      logic            mem_re;
      lattice_sel_type rd_sel;
      logic            take_near;
      logic            prod_en;
      lattice_sel_type prod_axis;
      logic            acc_init;
      logic            acc_en;
      logic            out_en;
   } hlc_cmd_type;

   // Round a saturation or value coordinate to its lattice level and pick the neighbor
   function automatic sv_axis_type sv_decode(input logic [SV_W-1:0] x);
      sv_axis_type        r;
      logic [SV_W:0]      rnd;
      logic [SV_W:0]      near;
      logic signed [SV_W+1:0] diff;
      logic signed [SV_W+1:0] neg;
      rnd    = {1'b0, x} + (SV_W+1)'(SV_GRID / 2);
      r.lvl0 = rnd[SV_W -: LVL_W];
      near   = (r.lvl0 == LVL_W'(SV_TOP)) ? (SV_W+1)'(SV_EDGE)
                                          : {r.lvl0, {SV_GRID_LOG{1'b0}}};
      diff   = $signed({2'b00, x}) - $signed({1'b0, near});
      neg    = -diff;
      if (diff > 0) begin
         r.mag    = diff[SV_MAG_W-1:0];
         r.lvl_nb = r.lvl0 + LVL_W'(1);
         r.den15  = (r.lvl0 == LVL_W'(SV_TOP - 1));
      end else if (diff < 0) begin
         r.mag    = neg[SV_MAG_W-1:0];
         r.lvl_nb = (r.lvl0 == LVL_W'(SV_TOP)) ? LVL_W'(SV_EDGE_NB_LEVEL)
                                               : r.lvl0 - LVL_W'(1);
         r.den15  = 1'b0;
      end else begin
         r.mag    = '0;
         r.lvl_nb = r.lvl0;
         r.den15  = 1'b0;
      end
      return r;
   endfunction

   // Fold a hue step back onto the circle
   function automatic logic [HSTEP_W-1:0] hue_wrap(input logic [HSTEP_RAW_W-1:0] x);
      logic [HSTEP_RAW_W-1:0] w;
      w = (x >= HSTEP_RAW_W'(HUE_STEPS)) ? x - HSTEP_RAW_W'(HUE_STEPS) : x;
      return w[HSTEP_W-1:0];
   endfunction

   // Table address of a lattice point
   function automatic logic [ADDR_W-1:0] entry_addr(input logic [LVL_W-1:0]   lv,
                                                    input logic [LVL_W-1:0]   ls,
                                                    input logic [HSTEP_W-1:0] hs);
      return ADDR_W'(lv) * ADDR_W'(PLANE_SIZE) + ADDR_W'(ls) * ADDR_W'(HUE_STEPS)
             + ADDR_W'(hs);
   endfunction

endpackage

/* design/hlc_ram.sv */
// Generic single-port RAM with registered read data.
// Standalone; no package needed.
module hlc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one word per enabled cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            store_ff[addr] <= wdata;
         end else begin
            rdata_ff <= store_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

/* design/hlc_ctrl.sv */
// Sequencer for the lattice interpolator: accepts beats, steps the four table reads
// and the correction pipeline. Depends on hlc_pkg.
module hlc_ctrl
   import hlc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        req_action,
   output logic        busy,
   output logic        rsp_valid,
   output hlc_cmd_type cmd
);

   typedef enum logic [2:0] {
      IDLE,
      RD_NEAR,
      RD_HUE,
      RD_SAT,
      RD_VAL,
      PROD_VAL,
      FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;
   logic      accept;

   assign accept = start && !busy_ff;

   // Next state and datapath commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = SEL_NEAR;
      cmd.prod_axis = SEL_NEAR;
      unique case (state_ff)
         IDLE: begin
            cmd.load   = accept && (req_action == ACT_CONVERT);
            cmd.mem_we = accept && (req_action == ACT_WRITE);
            if (accept && (req_action == ACT_CONVERT)) begin
               state_in = RD_NEAR;
            end
         end
         RD_NEAR: begin
            cmd.mem_re = 1'b1;
            cmd.rd_sel = SEL_NEAR;
            state_in   = RD_HUE;
         end
         RD_HUE: begin
            cmd.mem_re    = 1'b1;
            cmd.rd_sel    = SEL_HUE;
            cmd.take_near = 1'b1;
            state_in      = RD_SAT;
         end
         RD_SAT: begin
            cmd.mem_re    = 1'b1;
            cmd.rd_sel    = SEL_SAT;
            cmd.prod_en   = 1'b1;
            cmd.prod_axis = SEL_HUE;
            cmd.acc_init  = 1'b1;
            state_in      = RD_VAL;
         end
         RD_VAL: begin
            cmd.mem_re    = 1'b1;
            cmd.rd_sel    = SEL_VAL;
            cmd.prod_en   = 1'b1;
            cmd.prod_axis = SEL_SAT;
            cmd.acc_en    = 1'b1;
            state_in      = PROD_VAL;
         end
         PROD_VAL: begin
            cmd.prod_en   = 1'b1;
            cmd.prod_axis = SEL_VAL;
            cmd.acc_en    = 1'b1;
            state_in      = FINISH;
         end
         FINISH: begin
            cmd.out_en = 1'b1;
            state_in   = IDLE;
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // Hold state, busy and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != IDLE);
         rsp_valid_ff <= (state_ff == FINISH);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/hlc_datapath.sv */
// Datapath of the lattice interpolator: pixel registers, lattice decode, table RAM,
// gradient products and the rounding accumulator. Depends on hlc_pkg and hlc_ram.
module hlc_datapath
   import hlc_pkg::*;
(
   input  logic               clock,
   input  hlc_cmd_type        cmd,
   input  logic [HUE_W-1:0]   req_hue,
   input  logic [SV_W-1:0]    req_saturation,
   input  logic [SV_W-1:0]    req_brightness,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [CHAN_W-1:0]  req_entry_cyan,
   input  logic [CHAN_W-1:0]  req_entry_magenta,
   input  logic [CHAN_W-1:0]  req_entry_yellow,
   output logic [CHAN_W-1:0]  rsp_cyan,
   output logic [CHAN_W-1:0]  rsp_magenta,
   output logic [CHAN_W-1:0]  rsp_yellow
);

   localparam int NCH      = 3;
   localparam int DC_W     = CHAN_W + 2;
   localparam int FULL_W   = HUE_MAG_W + 1 + DC_W;
   localparam int PROD_W   = 14;
   localparam int ACC_W    = 20;
   localparam int RECIP_W  = PROD_W + 13;
   localparam int HUE_SH   = FRAC_W - HUE_GRID_LOG;
   localparam int SV_SH    = FRAC_W - SV_GRID_LOG;
   localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(1 << (FRAC_W - 1));

   typedef enum logic [1:0] {
      SCALE_HUE,
      SCALE_SV,
      SCALE_EDGE
   } scale_type;

   // Scale a product |d|*dc into a correction with 8 fraction bits, truncated to zero
   function automatic logic signed [ACC_W-1:0] scale_prod(input logic signed [PROD_W-1:0] p,
                                                          input scale_type sc);
      logic signed [ACC_W-1:0] ext;
      logic [PROD_W-1:0]       m;
      logic [ACC_W-1:0]        whole;
      logic [RECIP_W-1:0]      frac_prod;
      logic [ACC_W-1:0]        q;
      logic signed [ACC_W-1:0] r;
      ext       = {{(ACC_W-PROD_W){p[PROD_W-1]}}, p};
      m         = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
      whole     = ACC_W'(m) * ACC_W'(DEN15_WHOLE);
      frac_prod = RECIP_W'(m) * RECIP_W'(DIV15_MUL);
      q         = whole + ACC_W'(frac_prod >> DIV15_SHIFT);
      case (sc)
         SCALE_HUE:  r = ext <<< HUE_SH;
         SCALE_SV:   r = ext <<< SV_SH;
         SCALE_EDGE: r = p[PROD_W-1] ? -$signed(q) : $signed(q);
         default:    r = '0;
      endcase
      return r;
   endfunction

   logic [HUE_W-1:0]  hue_ff;
   logic [SV_W-1:0]   sat_ff;
   logic [SV_W-1:0]   bri_ff;
   logic [ENTRY_W-1:0] e0_ff;

   logic signed [PROD_W-1:0] p_ff   [NCH];
   logic signed [PROD_W-1:0] p_in   [NCH];
   scale_type                scale_ff, scale_in;
   logic signed [ACC_W-1:0]  acc_ff [NCH];
   logic signed [ACC_W-1:0]  acc_in [NCH];
   logic signed [ACC_W-1:0]  sum    [NCH];
   logic [CHAN_W-1:0]        res_ff [NCH];
   logic [CHAN_W-1:0]        res_in [NCH];

   logic [HUE_W:0]             hue_rnd;
   logic [HSTEP_RAW_W-1:0]     hstep0;
   logic [HSTEP_RAW_W-1:0]     hstep_nb;
   logic signed [HUE_W+1:0]    hdiff;
   logic [HUE_W+1:0]           habs;
   logic [HUE_MAG_W-1:0]       hmag;
   logic [HSTEP_W-1:0]         h0;
   logic [HSTEP_W-1:0]         hn;
   sv_axis_type                sdec;
   sv_axis_type                vdec;

   logic [ADDR_W-1:0]  ram_addr;
   logic               ram_en;
   logic               ram_we;
   logic               wr_ok;
   logic [ENTRY_W-1:0] ram_rdata;
   logic [HUE_MAG_W-1:0] mag;

   // Round hue to its lattice step and pick the enclosing neighbor
   always_comb begin
      hue_rnd  = {1'b0, hue_ff} + (HUE_W+1)'(1 << (HUE_GRID_LOG - 1));
      hstep0   = hue_rnd[HUE_W -: HSTEP_RAW_W];
      hdiff    = $signed({2'b00, hue_ff}) - $signed({1'b0, hstep0, {HUE_GRID_LOG{1'b0}}});
      habs     = (hdiff < 0) ? (HUE_W+2)'(-hdiff) : (HUE_W+2)'(hdiff);
      hmag     = habs[HUE_MAG_W-1:0];
      if (hdiff > 0) begin
         hstep_nb = hstep0 + HSTEP_RAW_W'(1);
      end else if (hdiff < 0) begin
         hstep_nb = hstep0 - HSTEP_RAW_W'(1);
      end else begin
         hstep_nb = hstep0;
      end
      h0   = hue_wrap(hstep0);
      hn   = hue_wrap(hstep_nb);
      sdec = sv_decode(sat_ff);
      vdec = sv_decode(bri_ff);
   end

   // Select the table address: load writes, or one of the four lattice reads
   always_comb begin
      wr_ok = (req_entry_index < INDEX_W'(TABLE_DEPTH));
      if (cmd.mem_we) begin
         ram_addr = req_entry_index[ADDR_W-1:0];
      end else begin
         case (cmd.rd_sel)
            SEL_NEAR: ram_addr = entry_addr(vdec.lvl0,   sdec.lvl0,   h0);
            SEL_HUE:  ram_addr = entry_addr(vdec.lvl0,   sdec.lvl0,   hn);
            SEL_SAT:  ram_addr = entry_addr(vdec.lvl0,   sdec.lvl_nb, h0);
            SEL_VAL:  ram_addr = entry_addr(vdec.lvl_nb, sdec.lvl0,   h0);
            default:  ram_addr = '0;
         endcase
      end
      ram_we = cmd.mem_we && wr_ok;
      ram_en = ram_we || cmd.mem_re;
   end

   hlc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata ({req_entry_cyan, req_entry_magenta, req_entry_yellow}),
      .rdata (ram_rdata)
   );

   // Form the per-axis distance and scale for the neighbor now on the read port
   always_comb begin
      case (cmd.prod_axis)
         SEL_HUE: begin
            mag      = hmag;
            scale_in = SCALE_HUE;
         end
         SEL_SAT: begin
            mag      = HUE_MAG_W'(sdec.mag);
            scale_in = sdec.den15 ? SCALE_EDGE : SCALE_SV;
         end
         SEL_VAL: begin
            mag      = HUE_MAG_W'(vdec.mag);
            scale_in = vdec.den15 ? SCALE_EDGE : SCALE_SV;
         end
         default: begin
            mag      = '0;
            scale_in = SCALE_HUE;
         end
      endcase
   end

   // One lane per color: product, accumulate, then round and clamp
   always_comb begin
      for (int k = 0; k < NCH; k++) begin
         logic [CHAN_W-1:0]       c0;
         logic [CHAN_W-1:0]       cn;
         logic signed [DC_W-1:0]  dc;
         logic signed [FULL_W-1:0] full;
         c0   = e0_ff[ENTRY_W-1-CHAN_W*k -: CHAN_W];
         cn   = ram_rdata[ENTRY_W-1-CHAN_W*k -: CHAN_W];
         dc   = $signed({2'b00, cn}) - $signed({2'b00, c0});
         full = $signed({1'b0, mag}) * dc;
         p_in[k] = full[PROD_W-1:0];
         sum[k]  = acc_ff[k] + scale_prod(p_ff[k], scale_ff);
         acc_in[k] = cmd.acc_init
                   ? $signed({{(ACC_W-CHAN_W-FRAC_W){1'b0}}, c0, ROUND_HALF})
                   : sum[k];
         if (sum[k][ACC_W-1]) begin
            res_in[k] = '0;
         end else if (|sum[k][ACC_W-2:FRAC_W+CHAN_W]) begin
            res_in[k] = '1;
         end else begin
            res_in[k] = sum[k][FRAC_W +: CHAN_W];
         end
      end
   end

   // Advance the pixel, near entry, product, accumulator and result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hue_ff <= req_hue;
         sat_ff <= req_saturation;
         bri_ff <= req_brightness;
      end
      if (cmd.take_near) begin
         e0_ff <= ram_rdata;
      end
      if (cmd.prod_en) begin
         p_ff     <= p_in;
         scale_ff <= scale_in;
      end
      if (cmd.acc_init || cmd.acc_en) begin
         acc_ff <= acc_in;
      end
      if (cmd.out_en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_cyan    = res_ff[0];
   assign rsp_magenta = res_ff[1];
   assign rsp_yellow  = res_ff[2];

endmodule

/* design/hsv_lattice_to_cmy_interpolator_core.sv */
// HSV to CMY lattice interpolator, top level: controller plus datapath.
// Depends on hlc_pkg, hlc_ctrl, hlc_datapath (which holds hlc_ram).
//
// A beat is accepted when start is high and busy is low. A table write (action 0)
// leaves busy low, so writes can stream every cycle while no convert holds busy; an
// entry index at or beyond 13872 is dropped. A convert (action 1) raises busy and
// returns its result on rsp_cyan/magenta/yellow with rsp_valid high for exactly one
// cycle, as busy falls; the next beat can be taken in that same cycle, so converts
// do not overlap. The convert sequence is set by the four lattice reads (nearest
// point and its hue, saturation and value neighbors) through the single table RAM
// port, followed by the two-stage product and scale pipeline. The receiver cannot
// stall: capture the result in the strobe cycle. The table is not cleared by reset;
// every entry a convert touches must be written first.
module hsv_lattice_to_cmy_interpolator_core
   import hlc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [HUE_W-1:0]   req_hue,
   input  logic [SV_W-1:0]    req_saturation,
   input  logic [SV_W-1:0]    req_brightness,
   input  logic [INDEX_W-1:0] req_entry_index,
   input  logic [CHAN_W-1:0]  req_entry_cyan,
   input  logic [CHAN_W-1:0]  req_entry_magenta,
   input  logic [CHAN_W-1:0]  req_entry_yellow,
   output logic               rsp_valid,
   output logic [CHAN_W-1:0]  rsp_cyan,
   output logic [CHAN_W-1:0]  rsp_magenta,
   output logic [CHAN_W-1:0]  rsp_yellow
);

   hlc_cmd_type cmd;

   hlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd)
   );

   hlc_datapath u_datapath (
      .clock             (clock),
      .cmd               (cmd),
      .req_hue           (req_hue),
      .req_saturation    (req_saturation),
      .req_brightness    (req_brightness),
      .req_entry_index   (req_entry_index),
      .req_entry_cyan    (req_entry_cyan),
      .req_entry_magenta (req_entry_magenta),
      .req_entry_yellow  (req_entry_yellow),
      .rsp_cyan          (rsp_cyan),
      .rsp_magenta       (rsp_magenta),
      .rsp_yellow        (rsp_yellow)
   );

   // One result per convert, never back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // A convert beat occupies the block
   a_convert_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_CONVERT)) |=> busy)
      else $error("convert accepted without raising busy");

   // A write beat completes in its own cycle
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_WRITE)) |=> !busy)
      else $error("table write raised busy");

   // A result appears exactly as the block frees up
   a_strobe_at_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $fell(busy))
      else $error("result strobe not aligned with end of busy");

endmodule

/* tb/tb_hsv_lattice_to_cmy_interpolator_core.sv */
// Testbench for hsv_lattice_to_cmy_interpolator_core: loads the lattice region that the pixel
// stimulus reaches, then runs directed and random table writes and pixel converts against a
// built-in CMY predictor. Depends on hlc_pkg and the core's RTL only.
`timescale 1ns / 1ps

module tb_hsv_lattice_to_cmy_interpolator_core;
   import hlc_pkg::*;

   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int DRAIN_CYCLES = 16;
   localparam int REPORT_MAX   = 10;
   localparam int RANDOM_BEATS = 680;
   localparam int HUE_SNAP     = 32;
   localparam int SV_SNAP      = 16;

   typedef struct {
      logic [CHAN_W-1:0] cyan;
      logic [CHAN_W-1:0] magenta;
      logic [CHAN_W-1:0] yellow;
   } cmy_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic               req_action;
   logic [HUE_W-1:0]   req_hue;
   logic [SV_W-1:0]    req_saturation;
   logic [SV_W-1:0]    req_brightness;
   logic [INDEX_W-1:0] req_entry_index;
   logic [CHAN_W-1:0]  req_entry_cyan;
   logic [CHAN_W-1:0]  req_entry_magenta;
   logic [CHAN_W-1:0]  req_entry_yellow;
   logic               rsp_valid;
   logic [CHAN_W-1:0]  rsp_cyan;
   logic [CHAN_W-1:0]  rsp_magenta;
   logic [CHAN_W-1:0]  rsp_yellow;

   // Shadow copy of the lattice table and the colors still owed by the core
   logic [ENTRY_W-1:0] cmy_table [TABLE_DEPTH];
   cmy_type            pending_cmy [$];
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 gap_pct     = 0;

   // Saturation/value levels and hue steps that the pixel stimulus can reach
   int                 reach_levels [6] = '{0, 1, 2, 14, 15, 16};
   int                 reach_steps  [7] = '{0, 1, 2, 15, 16, 46, 47};

   hsv_lattice_to_cmy_interpolator_core u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_hue           (req_hue),
      .req_saturation    (req_saturation),
      .req_brightness    (req_brightness),
      .req_entry_index   (req_entry_index),
      .req_entry_cyan    (req_entry_cyan),
      .req_entry_magenta (req_entry_magenta),
      .req_entry_yellow  (req_entry_yellow),
      .rsp_valid         (rsp_valid),
      .rsp_cyan          (rsp_cyan),
      .rsp_magenta       (rsp_magenta),
      .rsp_yellow        (rsp_yellow)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   // Snap a saturation/value coordinate to its lattice point; 256 folds to 255
   function automatic int snap_sv(input int x);
      int n;
      n = ((x + SV_SNAP / 2) / SV_SNAP) * SV_SNAP;
      return (n == 256) ? 255 : n;
   endfunction

   // Enclosing lattice point on the far side of the pixel from its nearest point
   function automatic int far_point(input int x, input int n, input int grid, input bit sv_axis);
      int r;
      if (x == n) return x;
      r = (n < x) ? n + grid : n - grid;
      if (sv_axis && r == 256) r = 255;
      return r;
   endfunction

   // Table row of a saturation/value coordinate; anything above 240 is the top row
   function automatic int sv_row(input int x);
      return (x > 240) ? SV_LEVELS - 1 : x / SV_SNAP;
   endfunction

   function automatic logic [ENTRY_W-1:0] lattice_at(input int h, input int s, input int v);
      int addr;
      addr = sv_row(v) * PLANE_SIZE + sv_row(s) * HUE_STEPS + (h / HUE_SNAP) % HUE_STEPS;
      return cmy_table[addr];
   endfunction

   // Gradient correction of one axis in fixed point with 8 fraction bits, truncated toward zero
   function automatic int slope_term(input int x, input int n, input int a,
                                     input int c_near, input int c_far);
      if (x == n || a == n) return 0;
      return ((x - n) * (c_far - c_near) * 256) / (a - n);
   endfunction

   function automatic cmy_type predict_cmy(input int h, input int s, input int v);
      int nh, ns, nv, ah, as, av, sh, c0, acc, res;
      logic [ENTRY_W-1:0] e_near, e_hue, e_sat, e_val;
      logic [CHAN_W-1:0]  chan [3];
      cmy_type            out;
      nh = ((h + HUE_SNAP / 2) / HUE_SNAP) * HUE_SNAP;
      ns = snap_sv(s);
      nv = snap_sv(v);
      ah = far_point(h, nh, HUE_SNAP, 1'b0);
      as = far_point(s, ns, SV_SNAP, 1'b1);
      av = far_point(v, nv, SV_SNAP, 1'b1);
      e_near = lattice_at(nh, ns, nv);
      e_hue  = lattice_at(ah, ns, nv);
      e_sat  = lattice_at(nh, as, nv);
      e_val  = lattice_at(nh, ns, av);
      for (int k = 0; k < 3; k++) begin
         sh  = 16 - 8 * k;
         c0  = int'((e_near >> sh) & 'hFF);
         acc = c0 * 256 + 128
             + slope_term(h, nh, ah, c0, int'((e_hue >> sh) & 'hFF))
             + slope_term(s, ns, as, c0, int'((e_sat >> sh) & 'hFF))
             + slope_term(v, nv, av, c0, int'((e_val >> sh) & 'hFF));
         res = (acc < 0) ? 0 : acc / 256;
         if (res > 255) res = 255;
         chan[k] = CHAN_W'(res);
      end
      out.cyan    = chan[0];
      out.magenta = chan[1];
      out.yellow  = chan[2];
      return out;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_fault(input string what, input int want, input int got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Retire results against the oldest prediction, then take in the beat of this edge
   always @(posedge clock) begin : monitor
      cmy_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_cmy.size() == 0) begin
               report_fault("unexpected result strobe", 0, 1);
            end else begin
               want = pending_cmy.pop_front();
               if (rsp_cyan !== want.cyan) report_fault("cyan", want.cyan, rsp_cyan);
               if (rsp_magenta !== want.magenta)
                  report_fault("magenta", want.magenta, rsp_magenta);
               if (rsp_yellow !== want.yellow) report_fault("yellow", want.yellow, rsp_yellow);
            end
         end
         if (start && !busy) begin
            if (req_action == ACT_WRITE) begin
               if (req_entry_index < TABLE_DEPTH)
                  cmy_table[req_entry_index] = {req_entry_cyan, req_entry_magenta,
                                                req_entry_yellow};
            end else begin
               pending_cmy.push_back(predict_cmy(req_hue, req_saturation, req_brightness));
            end
         end
      end
   end

   // Hard stop if the core hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic int pick_gap();
      int r;
      if ($urandom_range(99) >= gap_pct) return 0;
      r = $urandom_range(99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 93) return $urandom_range(4, 9);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [CHAN_W-1:0] pick_byte();
      int r;
      r = $urandom_range(99);
      if (r < 12) return '0;
      if (r < 24) return '1;
      return CHAN_W'($urandom);
   endfunction

   // Low band reaches levels 0..2, high band levels 14..16
   function automatic logic [SV_W-1:0] pick_sv();
      int edges [11] = '{0, 7, 8, 9, 239, 240, 241, 247, 248, 254, 255};
      if ($urandom_range(99) < 20) return SV_W'(edges[$urandom_range(10)]);
      if ($urandom_range(99) < 50) return SV_W'($urandom_range(24));
      return SV_W'($urandom_range(232, 255));
   endfunction

   // Bands reach hue steps 0..2, 46..47 with the wrap, and 15..16 past full circle
   function automatic logic [HUE_W-1:0] pick_hue();
      int edges [8] = '{0, 15, 16, 17, 1520, 1535, 1536, 2047};
      int r;
      r = $urandom_range(99);
      if (r < 10) return HUE_W'(edges[$urandom_range(7)]);
      if (r < 45) return HUE_W'($urandom_range(48));
      if (r < 85) return HUE_W'($urandom_range(1488, 1584));
      return HUE_W'($urandom_range(2032, 2047));
   endfunction

   function automatic logic [INDEX_W-1:0] lattice_index(input int vl, input int sl, input int hs);
      return INDEX_W'(vl * PLANE_SIZE + sl * HUE_STEPS + hs);
   endfunction

   // Present one beat from the falling edge, hold it until taken, then maybe idle
   task automatic send_beat(input logic act, input logic [HUE_W-1:0] h,
                            input logic [SV_W-1:0] s, input logic [SV_W-1:0] v,
                            input logic [INDEX_W-1:0] idx, input logic [CHAN_W-1:0] c,
                            input logic [CHAN_W-1:0] m, input logic [CHAN_W-1:0] y);
      int gap;
      @(negedge clock);
      start             <= 1'b1;
      req_action        <= act;
      req_hue           <= h;
      req_saturation    <= s;
      req_brightness    <= v;
      req_entry_index   <= idx;
      req_entry_cyan    <= c;
      req_entry_magenta <= m;
      req_entry_yellow  <= y;
      do @(posedge clock); while (busy);
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         start             <= 1'b0;
         req_action        <= 1'($urandom);
         req_hue           <= HUE_W'($urandom);
         req_saturation    <= SV_W'($urandom);
         req_brightness    <= SV_W'($urandom);
         req_entry_index   <= INDEX_W'($urandom);
         req_entry_cyan    <= CHAN_W'($urandom);
         req_entry_magenta <= CHAN_W'($urandom);
         req_entry_yellow  <= CHAN_W'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [CHAN_W-1:0] c,
                              input logic [CHAN_W-1:0] m, input logic [CHAN_W-1:0] y);
      send_beat(ACT_WRITE, HUE_W'($urandom), SV_W'($urandom), SV_W'($urandom), idx, c, m, y);
   endtask

   task automatic convert_pixel(input int h, input int s, input int v);
      send_beat(ACT_CONVERT, HUE_W'(h), SV_W'(s), SV_W'(v), INDEX_W'($urandom),
                CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
   endtask

   // ---------------------------------------------------------------- tests

   // Fill every entry the pixel stimulus can reach so no convert touches an unwritten one
   task automatic test_table_load();
      gap_pct = 5;
      for (int vi = 0; vi < 6; vi++)
         for (int si = 0; si < 6; si++)
            for (int hi = 0; hi < 7; hi++)
               write_entry(lattice_index(reach_levels[vi], reach_levels[si], reach_steps[hi]),
                           pick_byte(), pick_byte(), pick_byte());
   endtask

   // Pixels on lattice points need no correction
   task automatic test_lattice_points();
      gap_pct = 30;
      convert_pixel(0, 0, 0);
      convert_pixel(1536, 255, 255);
      convert_pixel(1504, 16, 240);
      convert_pixel(2016, 240, 16);
   endtask

   // Hue wrap at and beyond full circle, top-row edge rule on saturation and value
   task automatic test_axis_edges();
      gap_pct = 0;
      convert_pixel(15, 7, 9);
      convert_pixel(17, 241, 247);
      convert_pixel(1530, 248, 250);
      convert_pixel(2047, 255, 254);
      convert_pixel(1535, 1, 239);
      convert_pixel(16, 8, 8);
      convert_pixel(1520, 247, 241);
      convert_pixel(48, 24, 232);
   endtask

   // Drive one channel past 255, one below 0 and leave one in range
   task automatic test_clipping();
      gap_pct = 50;
      write_entry(lattice_index(1, 1, 1), 8'd200, 8'd10, 8'd100);
      write_entry(lattice_index(1, 1, 0), 8'd255, 8'd0, 8'd255);
      write_entry(lattice_index(1, 0, 1), 8'd255, 8'd0, 8'd0);
      write_entry(lattice_index(0, 1, 1), 8'd255, 8'd0, 8'd0);
      convert_pixel(16, 8, 8);
   endtask

   // Writes at or past the table depth must leave the table alone
   task automatic test_index_range();
      gap_pct = 0;
      write_entry(INDEX_W'(TABLE_DEPTH), 8'd255, 8'd255, 8'd255);
      write_entry('1, 8'd0, 8'd0, 8'd0);
      write_entry(INDEX_W'(TABLE_DEPTH - 1), 8'd0, 8'd255, 8'd17);
      convert_pixel(1504, 255, 255);
      convert_pixel(1536, 255, 255);
   endtask

   // Mixed table updates and converts, alternating stretches with and without idling
   task automatic test_random_traffic();
      logic [INDEX_W-1:0] idx;
      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 150 == 0) gap_pct = (gap_pct == 0) ? 40 : 0;
         if ($urandom_range(99) < 30) begin
            idx = ($urandom_range(99) < 8)
                ? INDEX_W'($urandom_range(TABLE_DEPTH, 16383))
                : lattice_index(reach_levels[$urandom_range(5)],
                                reach_levels[$urandom_range(5)],
                                reach_steps[$urandom_range(6)]);
            write_entry(idx, pick_byte(), pick_byte(), pick_byte());
         end else begin
            convert_pixel(pick_hue(), pick_sv(), pick_sv());
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset             = 1'b1;
      start             = 1'b0;
      req_action        = ACT_WRITE;
      req_hue           = '0;
      req_saturation    = '0;
      req_brightness    = '0;
      req_entry_index   = '0;
      req_entry_cyan    = '0;
      req_entry_magenta = '0;
      req_entry_yellow  = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_table_load();
      test_lattice_points();
      test_axis_edges();
      test_clipping();
      test_index_range();
      test_random_traffic();

      // Release start and drain the last results
      @(negedge clock);
      start <= 1'b0;
      while (pending_cmy.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (pending_cmy.size() != 0) begin
         $display("%0d results never arrived", pending_cmy.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
